FILE: hw/rtl/hksd_pkg.sv
// Shared constants, codes and controller/datapath interface types for the descrambler.
`default_nettype none

package hksd_pkg;

   localparam int MAX_HEADERS_DEF      = 9;
   localparam int MAX_HEADER_BYTES_DEF = 80;

   localparam logic [7:0] DATA_START = 8'd7;
   localparam logic [7:0] DATA_STEP  = 8'd13;

   localparam logic [3:0] HEADER_COUNT_RESET = 4'd9;

   localparam logic [1:0] OP_SET_LEN  = 2'd0;
   localparam logic [1:0] OP_WR_BYTE  = 2'd1;
   localparam logic [1:0] OP_BUILD    = 2'd2;
   localparam logic [1:0] OP_DECRYPT  = 2'd3;

   localparam logic [1:0] MODE_MODEL  = 2'd0;
   localparam logic [1:0] MODE_MEDIA  = 2'd1;
   localparam logic [1:0] MODE_DATA   = 2'd2;
   localparam logic [1:0] MODE_NONE   = 2'd3;

   typedef struct packed {
      logic take;
      logic res_zero;
      logic res_dec;
      logic max_clr;
      logic max_step;
      logic key_set;
      logic mod_clr;
      logic mod_step;
      logic seed_clr;
      logic seed_acc;
      logic hdr_next;
      logic tab_clr;
      logic fill_step;
      logic tab_start;
      logic red_step;
      logic tab_rd;
      logic tab_step;
   } dp_cmd_type;

   typedef struct packed {
      logic h_done;
      logic seed_skip;
      logic len_zero;
      logic j_last;
      logic mod_last;
      logic key_len_zero;
      logic mx_zero;
      logic i_last;
      logic red_done;
      logic out_free;
   } dp_sts_type;

endpackage

`default_nettype wire

FILE: hw/rtl/hksd_datapath.sv
// Datapath: header store, key table, build counters, decrypt state and result register.
`default_nettype none

module hksd_datapath #(
   parameter int MAX_HEADERS      = hksd_pkg::MAX_HEADERS_DEF,
   parameter int MAX_HEADER_BYTES = hksd_pkg::MAX_HEADER_BYTES_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire hksd_pkg::dp_cmd_type cmd,
   output hksd_pkg::dp_sts_type      sts,
   input  wire logic [1:0]           req_opcode,
   input  wire logic [3:0]           req_header_index,
   input  wire logic [6:0]           req_byte_position,
   input  wire logic [6:0]           req_header_length,
   input  wire logic [7:0]           req_data_byte,
   input  wire logic [1:0]           req_key_mode,
   input  wire logic                 csr_valid,
   input  wire logic [3:0]           csr_header_count,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output logic [7:0]                rsp_plain_byte,
   output logic                      rsp_is_data
);

   localparam int HIW   = $clog2(MAX_HEADERS);
   localparam int HCW   = $clog2(MAX_HEADERS + 1);
   localparam int LW    = $clog2(MAX_HEADER_BYTES + 1);
   localparam int TW    = $clog2(MAX_HEADER_BYTES);
   localparam int DEPTH = MAX_HEADERS * MAX_HEADER_BYTES;
   localparam int AW    = $clog2(DEPTH);

   logic [7:0]     hdr_mem [DEPTH];
   logic [7:0]     tab_mem [MAX_HEADER_BYTES];
   logic [LW-1:0]  len_ff [MAX_HEADERS];

   logic [3:0]     hc_ff;
   logic [7:0]     hq_ff, tq_ff;
   logic [LW-1:0]  key_len_ff;
   logic [31:0]    key_pos_ff;
   logic [TW-1:0]  key_idx_ff;
   logic [7:0]     prev_ff;
   logic [7:0]     d_ff;
   logic [1:0]     mode_ff;
   logic [HCW-1:0] h_ff;
   logic [7:0]     j_ff, r_ff, k_ff, acc_ff;
   logic [TW-1:0]  i_ff;
   logic [LW-1:0]  mx_ff;
   logic [LW:0]    rem_ff;
   logic [4:0]     mcnt_ff;
   logic           rsp_valid_ff;
   logic [7:0]     rsp_plain_ff;
   logic           rsp_is_data_ff;

   logic [HCW-1:0] n_used;
   logic [LW-1:0]  lenh, len_sat;
   logic [AW-1:0]  hdr_rd_addr, hdr_wr_addr;
   logic [TW-1:0]  tab_rd_addr;
   logic [7:0]     key_byte, c_byte, jp, contrib, s_start, r_wrap;
   logic [15:0]    prod;
   logic [LW:0]    mod_t, mod_n;
   logic           hdr_wr_en;

   always_comb begin
      n_used = (32'(hc_ff) > MAX_HEADERS) ? HCW'(MAX_HEADERS) : HCW'(hc_ff);
      lenh = (32'(h_ff) < MAX_HEADERS) ? len_ff[h_ff[HIW-1:0]] : '0;
      len_sat = (32'(req_header_length) > MAX_HEADER_BYTES) ? LW'(MAX_HEADER_BYTES)
                                                            : LW'(req_header_length);
      hdr_rd_addr = AW'(32'(h_ff[HIW-1:0]) * MAX_HEADER_BYTES + 32'(r_ff));
      hdr_wr_addr = AW'(32'(req_header_index[HIW-1:0]) * MAX_HEADER_BYTES
                        + 32'(req_byte_position));
      hdr_wr_en = cmd.take && (req_opcode == hksd_pkg::OP_WR_BYTE)
                  && (32'(req_header_index) < MAX_HEADERS)
                  && (32'(req_byte_position) < MAX_HEADER_BYTES);
      tab_rd_addr = cmd.tab_rd ? i_ff : key_idx_ff;
      key_byte = (key_len_ff == '0) ? 8'd0 : tq_ff;
      c_byte = (lenh == '0) ? 8'd0 : hq_ff;
      jp = j_ff + 8'd1;
      prod = 16'(c_byte) * 16'(jp);
      contrib = (mode_ff == hksd_pkg::MODE_MODEL) ? hq_ff
                : 8'(8'(h_ff) + j_ff + prod[7:0]);
      case (mode_ff)
         hksd_pkg::MODE_MODEL: s_start = 8'd0;
         hksd_pkg::MODE_MEDIA: s_start = 8'(h_ff);
         default:              s_start = 8'(hksd_pkg::DATA_START
                                             + 8'(hksd_pkg::DATA_STEP * 8'(h_ff)));
      endcase
      r_wrap = ((9'(r_ff) + 9'd1) == 9'(lenh)) ? 8'd0 : r_ff + 8'd1;
      mod_t = {rem_ff[LW-1:0], key_pos_ff[~mcnt_ff]};
      mod_n = (mod_t >= (LW+1)'(mx_ff)) ? mod_t - (LW+1)'(mx_ff) : mod_t;
   end

   assign sts.h_done       = (h_ff == n_used);
   assign sts.seed_skip    = (mx_ff == '0) || ((mode_ff == hksd_pkg::MODE_MODEL) && (lenh == '0));
   assign sts.len_zero     = (lenh == '0);
   assign sts.j_last       = ((9'(j_ff) + 9'd1) == 9'(mx_ff));
   assign sts.mod_last     = (mcnt_ff == 5'd31);
   assign sts.key_len_zero = (key_len_ff == '0);
   assign sts.mx_zero      = (mx_ff == '0);
   assign sts.i_last       = (((LW+1)'(i_ff) + (LW+1)'(1)) == (LW+1)'(key_len_ff));
   assign sts.red_done     = (9'(r_ff) < 9'(lenh));
   assign sts.out_free     = !rsp_valid_ff || rsp_ready;

   // Memories
   always_ff @(posedge clock) begin
      if (hdr_wr_en) begin
         hdr_mem[hdr_wr_addr] <= req_data_byte;
      end
      hq_ff <= hdr_mem[hdr_rd_addr];
   end

   always_ff @(posedge clock) begin
      if (cmd.fill_step) begin
         tab_mem[i_ff] <= acc_ff;
      end else if (cmd.tab_step) begin
         tab_mem[i_ff] <= tq_ff ^ hq_ff;
      end
      tq_ff <= tab_mem[tab_rd_addr];
   end

   // Control-like state with reset values
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int x = 0; x < MAX_HEADERS; x++) begin
            len_ff[x] <= '0;
         end
         hc_ff        <= hksd_pkg::HEADER_COUNT_RESET;
         key_len_ff   <= '0;
         key_pos_ff   <= '0;
         key_idx_ff   <= '0;
         prev_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            hc_ff <= csr_header_count;
         end
         if (cmd.take && (req_opcode == hksd_pkg::OP_SET_LEN)
             && (32'(req_header_index) < MAX_HEADERS)) begin
            len_ff[req_header_index[HIW-1:0]] <= len_sat;
         end
         if (cmd.key_set && (key_len_ff == '0)) begin
            key_len_ff <= mx_ff;
         end
         if (cmd.mod_step && (mcnt_ff == 5'd31)) begin
            key_idx_ff <= TW'(mod_n);
         end
         if (cmd.res_dec) begin
            prev_ff    <= d_ff;
            key_pos_ff <= key_pos_ff + 32'd1;
            if (key_len_ff != '0) begin
               key_idx_ff <= ((LW'(key_idx_ff) + LW'(1)) == key_len_ff) ? '0
                             : key_idx_ff + TW'(1);
            end
         end
         if (cmd.res_zero || cmd.res_dec) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload and build counters
   always_ff @(posedge clock) begin
      if (cmd.take) begin
         d_ff    <= req_data_byte;
         mode_ff <= req_key_mode;
      end
      if (cmd.res_zero) begin
         rsp_plain_ff   <= 8'd0;
         rsp_is_data_ff <= 1'b0;
      end else if (cmd.res_dec) begin
         rsp_plain_ff   <= d_ff ^ prev_ff ^ key_byte;
         rsp_is_data_ff <= 1'b1;
      end
      if (cmd.max_clr) begin
         h_ff  <= '0;
         mx_ff <= '0;
      end
      if (cmd.max_step) begin
         h_ff <= h_ff + HCW'(1);
         if (lenh > mx_ff) begin
            mx_ff <= lenh;
         end
      end
      if (cmd.mod_clr) begin
         rem_ff  <= '0;
         mcnt_ff <= '0;
      end
      if (cmd.mod_step) begin
         rem_ff  <= mod_n;
         mcnt_ff <= mcnt_ff + 5'd1;
      end
      if (cmd.seed_clr) begin
         h_ff   <= '0;
         j_ff   <= '0;
         r_ff   <= '0;
         acc_ff <= '0;
      end
      if (cmd.seed_acc) begin
         acc_ff <= acc_ff ^ contrib;
         j_ff   <= j_ff + 8'd1;
         r_ff   <= (lenh == '0) ? 8'd0 : r_wrap;
      end
      if (cmd.tab_clr) begin
         h_ff <= '0;
         i_ff <= '0;
      end
      if (cmd.fill_step) begin
         i_ff <= i_ff + TW'(1);
      end
      if (cmd.tab_start) begin
         i_ff <= '0;
         r_ff <= s_start;
         k_ff <= s_start;
      end
      if (cmd.red_step) begin
         r_ff <= r_ff - 8'(lenh);
      end
      if (cmd.tab_step) begin
         i_ff <= i_ff + TW'(1);
         k_ff <= k_ff + 8'd1;
         r_ff <= ((mode_ff == hksd_pkg::MODE_DATA) && (k_ff == 8'hFF)) ? 8'd0 : r_wrap;
      end
      if (cmd.hdr_next) begin
         h_ff <= h_ff + HCW'(1);
         j_ff <= '0;
         r_ff <= '0;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_plain_byte = rsp_plain_ff;
   assign rsp_is_data    = rsp_is_data_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/hksd_ctrl.sv
// Controller: sequences transactions, key table builds and decrypts over the datapath.
`default_nettype none

module hksd_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire logic [1:0]           req_opcode,
   input  wire logic [1:0]           req_key_mode,
   input  wire hksd_pkg::dp_sts_type sts,
   output hksd_pkg::dp_cmd_type      cmd
);

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_DEC   = 4'd1;
   localparam logic [3:0] S_MAX   = 4'd2;
   localparam logic [3:0] S_MOD   = 4'd3;
   localparam logic [3:0] S_SEEDH = 4'd4;
   localparam logic [3:0] S_SEEDR = 4'd5;
   localparam logic [3:0] S_SEEDA = 4'd6;
   localparam logic [3:0] S_FILL  = 4'd7;
   localparam logic [3:0] S_TABH  = 4'd8;
   localparam logic [3:0] S_TRED  = 4'd9;
   localparam logic [3:0] S_TRD   = 4'd10;
   localparam logic [3:0] S_TWR   = 4'd11;
   localparam logic [3:0] S_DONE  = 4'd12;

   logic [3:0] state_ff, state_in;

   always_comb begin
      cmd       = '0;
      state_in  = state_ff;
      req_ready = (state_ff == S_IDLE) && sts.out_free;
      case (state_ff)
         S_IDLE: begin
            if (req_valid && req_ready) begin
               cmd.take = 1'b1;
               case (req_opcode)
                  hksd_pkg::OP_DECRYPT: state_in = S_DEC;
                  hksd_pkg::OP_BUILD: begin
                     if (req_key_mode == hksd_pkg::MODE_NONE) begin
                        cmd.res_zero = 1'b1;
                     end else begin
                        cmd.max_clr = 1'b1;
                        state_in    = S_MAX;
                     end
                  end
                  default: cmd.res_zero = 1'b1;
               endcase
            end
         end
         S_DEC: begin
            cmd.res_dec = 1'b1;
            state_in    = S_IDLE;
         end
         S_MAX: begin
            if (sts.h_done) begin
               cmd.key_set = 1'b1;
               if (sts.key_len_zero && sts.mx_zero) begin
                  state_in = S_DONE;
               end else if (sts.key_len_zero) begin
                  cmd.mod_clr = 1'b1;
                  state_in    = S_MOD;
               end else begin
                  cmd.seed_clr = 1'b1;
                  state_in     = S_SEEDH;
               end
            end else begin
               cmd.max_step = 1'b1;
            end
         end
         S_MOD: begin
            cmd.mod_step = 1'b1;
            if (sts.mod_last) begin
               cmd.seed_clr = 1'b1;
               state_in     = S_SEEDH;
            end
         end
         S_SEEDH: begin
            if (sts.h_done) begin
               if (sts.key_len_zero) begin
                  state_in = S_DONE;
               end else begin
                  cmd.tab_clr = 1'b1;
                  state_in    = S_FILL;
               end
            end else if (sts.seed_skip) begin
               cmd.hdr_next = 1'b1;
            end else begin
               state_in = S_SEEDR;
            end
         end
         S_SEEDR: state_in = S_SEEDA;
         S_SEEDA: begin
            cmd.seed_acc = 1'b1;
            if (sts.j_last) begin
               cmd.hdr_next = 1'b1;
               state_in     = S_SEEDH;
            end else begin
               state_in = S_SEEDR;
            end
         end
         S_FILL: begin
            cmd.fill_step = 1'b1;
            if (sts.i_last) begin
               state_in = S_TABH;
            end
         end
         S_TABH: begin
            if (sts.h_done) begin
               state_in = S_DONE;
            end else if (sts.len_zero) begin
               cmd.hdr_next = 1'b1;
            end else begin
               cmd.tab_start = 1'b1;
               state_in      = S_TRED;
            end
         end
         S_TRED: begin
            if (sts.red_done) begin
               state_in = S_TRD;
            end else begin
               cmd.red_step = 1'b1;
            end
         end
         S_TRD: begin
            cmd.tab_rd = 1'b1;
            state_in   = S_TWR;
         end
         S_TWR: begin
            cmd.tab_step = 1'b1;
            if (sts.i_last) begin
               cmd.hdr_next = 1'b1;
               state_in     = S_TABH;
            end else begin
               state_in = S_TRD;
            end
         end
         S_DONE: begin
            cmd.res_zero = 1'b1;
            state_in     = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

FILE: hw/rtl/header_keyed_stream_descrambler_unit.sv
// Top level of the header-keyed stream descrambler: controller plus datapath.
`default_nettype none

// One transaction at a time. Length writes, header byte writes and builds with the
// unused mode answer straight from idle; a decrypt passes through its own state
// (key table read, then result). A build walks the header lengths (one header a
// cycle), on the first build that fixes the key length divides the running
// position by it, then derives the seed over the longest length for each used
// header, reading then accumulating each header byte, fills the table (one entry
// a cycle) and folds in each header with a nonzero length, first reducing its
// start index, then reading and writing each table entry. The single-port header
// store paces these loops. The result register lets a finished result wait
// while the requester prepares the next transaction; the configuration register
// is always ready and must only be written while the block is idle.
module header_keyed_stream_descrambler_unit #(
   parameter int MAX_HEADERS      = hksd_pkg::MAX_HEADERS_DEF,
   parameter int MAX_HEADER_BYTES = hksd_pkg::MAX_HEADER_BYTES_DEF
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [1:0] req_opcode,
   input  wire logic [3:0] req_header_index,
   input  wire logic [6:0] req_byte_position,
   input  wire logic [6:0] req_header_length,
   input  wire logic [7:0] req_data_byte,
   input  wire logic [1:0] req_key_mode,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [7:0]      rsp_plain_byte,
   output logic            rsp_is_data,
   input  wire logic       csr_valid,
   output logic            csr_ready,
   input  wire logic [3:0] csr_header_count
);

   hksd_pkg::dp_cmd_type cmd;
   hksd_pkg::dp_sts_type sts;

   // Configuration writes land at once.
   assign csr_ready = 1'b1;

   hksd_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_opcode   (req_opcode),
      .req_key_mode (req_key_mode),
      .sts          (sts),
      .cmd          (cmd)
   );

   hksd_datapath #(
      .MAX_HEADERS      (MAX_HEADERS),
      .MAX_HEADER_BYTES (MAX_HEADER_BYTES)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .req_opcode        (req_opcode),
      .req_header_index  (req_header_index),
      .req_byte_position (req_byte_position),
      .req_header_length (req_header_length),
      .req_data_byte     (req_data_byte),
      .req_key_mode      (req_key_mode),
      .csr_valid         (csr_valid),
      .csr_header_count  (csr_header_count),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_plain_byte    (rsp_plain_byte),
      .rsp_is_data       (rsp_is_data)
   );

   // Never take a transaction while a result is stuck in the output register.
   a_ready_needs_room: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> (!rsp_valid || rsp_ready))
      else $error("transaction accepted with result register full");

   // Non-decrypt results carry a zero byte.
   a_zero_plain: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_is_data) |-> (rsp_plain_byte == 8'd0))
      else $error("non-decrypt result with nonzero byte");

   // A decrypt result, flagged as data, appears once its transaction has passed through S_DEC into the result register.
   a_dec_latency: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && (req_opcode == hksd_pkg::OP_DECRYPT))
      |-> ##2 (rsp_valid && rsp_is_data))
      else $error("decrypt result missing");

   // Hold the next transaction off until the previous result sits in the register.
   a_single_item: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (!req_ready || rsp_valid))
      else $error("second transaction accepted before result");

endmodule

`default_nettype wire

FILE: tb/sv/header_keyed_stream_descrambler_unit_tb.sv
// Self-checking testbench for the header-keyed stream descrambler unit.
`default_nettype none

module header_keyed_stream_descrambler_unit_tb;

   localparam int NHDR = hksd_pkg::MAX_HEADERS_DEF;
   localparam int NBYTES = hksd_pkg::MAX_HEADER_BYTES_DEF;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [1:0] req_opcode = hksd_pkg::OP_DECRYPT;
   logic [3:0] req_header_index = '0;
   logic [6:0] req_byte_position = '0;
   logic [6:0] req_header_length = '0;
   logic [7:0] req_data_byte = '0;
   logic [1:0] req_key_mode = hksd_pkg::MODE_MODEL;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [7:0] rsp_plain_byte;
   logic rsp_is_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [3:0] csr_header_count = hksd_pkg::HEADER_COUNT_RESET;

   header_keyed_stream_descrambler_unit DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_opcode(req_opcode),
      .req_header_index(req_header_index), .req_byte_position(req_byte_position),
      .req_header_length(req_header_length), .req_data_byte(req_data_byte),
      .req_key_mode(req_key_mode),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_plain_byte(rsp_plain_byte),
      .rsp_is_data(rsp_is_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_header_count(csr_header_count)
   );

   // Mirror of the block state used to work out each expected plain byte.
   bit [7:0] shadow_hdr [NHDR][NBYTES];
   bit written_mask [NHDR][NBYTES];
   bit [6:0] shadow_len [NHDR];
   bit [7:0] shadow_key [NBYTES];
   int unsigned shadow_key_len;
   bit [31:0] shadow_pos;
   bit [7:0] shadow_prev;
   bit [3:0] shadow_hcount = hksd_pkg::HEADER_COUNT_RESET;

   bit [7:0] expected_plain_q [$];
   bit expected_is_data_q [$];

   int fail_count = 0;
   int sent_count = 0;
   int decrypt_count = 0;
   int build_count = 0;
   int checked_count = 0;
   int send_idle_pct = 0;
   int rcv_idle_pct = 0;
   int hold_left = 0;

   initial forever #5 clock = ~clock;

   initial begin
      #20_000_000;
      $display("*** FAILED ***");
      $finish;
   end

   function automatic bit [7:0] hdr_at(int h, int p);
      return shadow_hdr[h][p % shadow_len[h]];
   endfunction

   // Derive the key table the way the block does for the given mode.
   function automatic void derive_key(bit [1:0] mode);
      int n, m, i, j;
      bit [7:0] seed, v, k, c;
      if (mode == hksd_pkg::MODE_NONE) return;
      n = (shadow_hcount > NHDR) ? NHDR : shadow_hcount;
      m = 0;
      for (i = 0; i < n; i++) if (shadow_len[i] > m) m = shadow_len[i];
      if (shadow_key_len == 0) shadow_key_len = m;
      seed = '0;
      for (i = 0; i < n; i++)
         for (j = 0; j < m; j++) begin
            if (mode == hksd_pkg::MODE_MODEL) begin
               if (shadow_len[i] != 0) seed ^= hdr_at(i, j);
            end else begin
               c = (shadow_len[i] != 0) ? hdr_at(i, j) : 8'd0;
               seed ^= 8'(i + j + int'(c) * (j + 1));
            end
         end
      for (i = 0; i < shadow_key_len; i++) begin
         v = seed;
         k = 8'(i) + hksd_pkg::DATA_START;
         for (j = 0; j < n; j++) begin
            if (shadow_len[j] != 0) begin
               case (mode)
                  hksd_pkg::MODE_MODEL: v ^= hdr_at(j, i);
                  hksd_pkg::MODE_MEDIA: v ^= hdr_at(j, i + j);
                  default: v ^= hdr_at(j, k);
               endcase
            end
            k = k + hksd_pkg::DATA_STEP;
         end
         shadow_key[i] = v;
      end
   endfunction

   // Apply one accepted transaction to the mirror and queue its result.
   function automatic void predict_result(bit [1:0] op, bit [3:0] hidx, bit [6:0] bpos,
                                          bit [6:0] hlen, bit [7:0] data, bit [1:0] mode);
      bit [7:0] plain, key;
      plain = '0;
      case (op)
         hksd_pkg::OP_SET_LEN:
            if (hidx < NHDR) shadow_len[hidx] = (hlen > NBYTES) ? 7'(NBYTES) : hlen;
         hksd_pkg::OP_WR_BYTE:
            if (hidx < NHDR && bpos < NBYTES) begin
               shadow_hdr[hidx][bpos] = data;
               written_mask[hidx][bpos] = 1'b1;
            end
         hksd_pkg::OP_BUILD: begin
            derive_key(mode);
            if (mode != hksd_pkg::MODE_NONE) build_count++;
         end
         default: begin
            key = (shadow_key_len != 0) ? shadow_key[shadow_pos % shadow_key_len] : 8'd0;
            plain = data ^ shadow_prev ^ key;
            shadow_pos = shadow_pos + 1;
            shadow_prev = data;
            decrypt_count++;
         end
      endcase
      expected_plain_q.push_back(plain);
      expected_is_data_q.push_back(op == hksd_pkg::OP_DECRYPT);
   endfunction

   // Longest length that may be set on a header without exposing unwritten bytes.
   function automatic int safe_len(int h);
      int p;
      p = 0;
      while (p < NBYTES && written_mask[h][p]) p++;
      return p;
   endfunction

   // Offer one transaction, hold it until accepted, then record its expectation.
   task automatic send_item(bit [1:0] op, bit [3:0] hidx, bit [6:0] bpos, bit [6:0] hlen,
                            bit [7:0] data, bit [1:0] mode);
      if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_opcode <= op;
      req_header_index <= hidx;
      req_byte_position <= bpos;
      req_header_length <= hlen;
      req_data_byte <= data;
      req_key_mode <= mode;
      do @(posedge clock); while (!req_ready);
      predict_result(op, hidx, bpos, hlen, data, mode);
      sent_count++;
   endtask

   // Drop valid and hold until every outstanding result has come back.
   task automatic drain();
      req_valid <= 1'b0;
      while (expected_plain_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_header_count(bit [3:0] value);
      drain();
      csr_valid <= 1'b1;
      csr_header_count <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      shadow_hcount = value;
   endtask

   task automatic send_decrypt();
      send_item(hksd_pkg::OP_DECRYPT, 4'($urandom), 7'($urandom), 7'($urandom),
                8'($urandom), 2'($urandom));
   endtask

   task automatic send_random();
      int r, h, lim;
      r = $urandom_range(99);
      h = $urandom_range(NHDR - 1);
      if (r < 50) send_decrypt();
      else if (r < 75) begin
         // mostly extend the written prefix, sometimes scatter or miss the store
         if ($urandom_range(9) < 7 && safe_len(h) < NBYTES)
            send_item(hksd_pkg::OP_WR_BYTE, 4'(h), 7'(safe_len(h)), 7'($urandom),
                      8'($urandom), 2'($urandom));
         else
            send_item(hksd_pkg::OP_WR_BYTE, 4'($urandom), 7'($urandom), 7'($urandom),
                      8'($urandom), 2'($urandom));
      end else if (r < 95) begin
         lim = safe_len(h);
         if ($urandom_range(9) == 0)
            send_item(hksd_pkg::OP_SET_LEN, 4'($urandom_range(NHDR, 15)), 7'($urandom),
                      7'($urandom), 8'($urandom), 2'($urandom));
         else if (lim == NBYTES && $urandom_range(1))
            send_item(hksd_pkg::OP_SET_LEN, 4'(h), 7'($urandom),
                      7'($urandom_range(NBYTES, 127)), 8'($urandom), 2'($urandom));
         else
            send_item(hksd_pkg::OP_SET_LEN, 4'(h), 7'($urandom), 7'($urandom_range(lim)),
                      8'($urandom), 2'($urandom));
      end else
         send_item(hksd_pkg::OP_BUILD, 4'($urandom), 7'($urandom), 7'($urandom),
                   8'($urandom), 2'($urandom));
   endtask

   // Result side: check each transaction, then decide ready for the next edge.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_plain_q.size() == 0) begin
            $error("unexpected result: plain_byte %0h is_data %0b", rsp_plain_byte,
                   rsp_is_data);
            fail_count++;
         end else begin
            if (rsp_plain_byte !== expected_plain_q[0]) begin
               $error("plain_byte: expected %0h, got %0h", expected_plain_q[0],
                      rsp_plain_byte);
               fail_count++;
            end
            if (rsp_is_data !== expected_is_data_q[0]) begin
               $error("is_data: expected %0b, got %0b", expected_is_data_q[0], rsp_is_data);
               fail_count++;
            end
            void'(expected_plain_q.pop_front());
            void'(expected_is_data_q.pop_front());
            checked_count++;
         end
      end
      if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else
         rsp_ready <= !(rcv_idle_pct > 0 && $urandom_range(99) < rcv_idle_pct);
   end

   // Decrypt before any key, builds with no lengths, unused mode, store edges.
   task automatic test_directed();
      send_item(hksd_pkg::OP_DECRYPT, '0, '0, '0, 8'h00, hksd_pkg::MODE_MODEL);
      send_item(hksd_pkg::OP_DECRYPT, '0, '0, '0, 8'hFF, hksd_pkg::MODE_MODEL);
      send_item(hksd_pkg::OP_BUILD, '0, '0, '0, 8'h00, hksd_pkg::MODE_MEDIA);
      send_item(hksd_pkg::OP_DECRYPT, '0, '0, '0, 8'hA5, hksd_pkg::MODE_MODEL);
      send_item(hksd_pkg::OP_WR_BYTE, 4'd15, 7'd3, '0, 8'h11, hksd_pkg::MODE_MODEL);
      send_item(hksd_pkg::OP_WR_BYTE, 4'd9, 7'd0, '0, 8'h22, hksd_pkg::MODE_MODEL);
      send_item(hksd_pkg::OP_WR_BYTE, 4'd0, 7'd127, '0, 8'h33, hksd_pkg::MODE_MODEL);
      send_item(hksd_pkg::OP_WR_BYTE, 4'd0, 7'd80, '0, 8'h44, hksd_pkg::MODE_MODEL);
      send_item(hksd_pkg::OP_SET_LEN, 4'd15, '0, 7'd127, 8'h00, hksd_pkg::MODE_MODEL);
      for (int b = 0; b < 3; b++)
         send_item(hksd_pkg::OP_WR_BYTE, 4'd0, 7'(b), '0, 8'(8'hF0 + b),
                   hksd_pkg::MODE_MODEL);
      send_item(hksd_pkg::OP_WR_BYTE, 4'd8, 7'd0, '0, 8'hFF, hksd_pkg::MODE_DATA);
      send_item(hksd_pkg::OP_WR_BYTE, 4'd8, 7'd1, '0, 8'h00, hksd_pkg::MODE_DATA);
      send_item(hksd_pkg::OP_SET_LEN, 4'd0, '0, 7'd3, 8'h00, hksd_pkg::MODE_MODEL);
      send_item(hksd_pkg::OP_SET_LEN, 4'd8, '0, 7'd2, 8'h00, hksd_pkg::MODE_MODEL);
      send_item(hksd_pkg::OP_BUILD, '0, '0, '0, 8'h00, hksd_pkg::MODE_NONE);
      send_item(hksd_pkg::OP_BUILD, '0, '0, '0, 8'h00, hksd_pkg::MODE_MODEL);
      send_item(hksd_pkg::OP_DECRYPT, '0, '0, '0, 8'h5A, hksd_pkg::MODE_MODEL);
      send_item(hksd_pkg::OP_BUILD, '0, '0, '0, 8'h00, hksd_pkg::MODE_MEDIA);
      send_item(hksd_pkg::OP_DECRYPT, '0, '0, '0, 8'hC3, hksd_pkg::MODE_MODEL);
      send_item(hksd_pkg::OP_BUILD, '0, '0, '0, 8'h00, hksd_pkg::MODE_DATA);
      send_item(hksd_pkg::OP_DECRYPT, '0, '0, '0, 8'h3C, hksd_pkg::MODE_MODEL);
      send_item(hksd_pkg::OP_DECRYPT, '0, '0, '0, 8'h01, hksd_pkg::MODE_MODEL);
   endtask

   // Fill one header completely and saturate its length from above.
   task automatic test_full_header();
      for (int b = 0; b < NBYTES; b++)
         send_item(hksd_pkg::OP_WR_BYTE, 4'd5, 7'(b), '0, 8'($urandom),
                   hksd_pkg::MODE_MODEL);
      send_item(hksd_pkg::OP_SET_LEN, 4'd5, '0, 7'd127, 8'h00, hksd_pkg::MODE_MODEL);
      send_item(hksd_pkg::OP_BUILD, '0, '0, '0, 8'h00, hksd_pkg::MODE_DATA);
      repeat (20) send_decrypt();
   endtask

   // Header count at its extremes: none used, above range, and both normal values.
   task automatic test_header_count();
      bit [3:0] counts [4] = '{4'd0, 4'd15, 4'd8, 4'd9};
      foreach (counts[c]) begin
         write_header_count(counts[c]);
         for (int m = 0; m < 3; m++) begin
            send_item(hksd_pkg::OP_BUILD, '0, '0, '0, 8'h00, 2'(m));
            repeat (4) send_decrypt();
         end
      end
   endtask

   // Hold the result side off while decrypts keep arriving, so the input stalls.
   task automatic test_backpressure();
      drain();
      hold_left <= 300;
      @(posedge clock);
      repeat (30) send_decrypt();
      drain();
   endtask

   task automatic test_random(int count);
      int plan [3][2] = '{'{32, 87}, '{87, 32}, '{0, 0}};
      foreach (plan[p]) begin
         send_idle_pct = plan[p][0];
         rcv_idle_pct = plan[p][1];
         repeat (count / 3) send_random();
         if (p == 1) write_header_count(4'($urandom_range(8, 9)));
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_full_header();
      test_header_count();
      test_backpressure();
      test_random(480);
      drain();
      repeat (50) @(posedge clock);
      $display("Covered %0d transactions: %0d decrypts, %0d key builds in all modes,",
               sent_count, decrypt_count, build_count);
      $display("header count extremes, stalls on both sides; %0d results checked.",
               checked_count);
      if (fail_count == 0 && expected_plain_q.size() == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

`default_nettype wire

FILE: files.f
hw/rtl/hksd_pkg.sv
hw/rtl/hksd_datapath.sv
hw/rtl/hksd_ctrl.sv
hw/rtl/header_keyed_stream_descrambler_unit.sv
tb/sv/header_keyed_stream_descrambler_unit_tb.sv
